>>> hdl/next_lexicographic_permutation_macros.svh
// Assertion macros for the next_lexicographic_permutation checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define NLP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/nlp_pkg.sv
// Package for the next lexicographic permutation block: sizes, types, lane helper.
// Depends on nothing; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps

package nlp_pkg;

   localparam int ELEMENT_COUNT = 8;
   localparam int ELEMENT_WIDTH = 8;
   localparam int ROW_W         = 64;
   localparam int ACTIVE_LEN_W  = 4;
   localparam int IDX_W         = $clog2(ELEMENT_COUNT);
   localparam int LEN_W         = $clog2(ELEMENT_COUNT + 1);
   localparam int SRC_W         = LEN_W + 1;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;
   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic [ACTIVE_LEN_W-1:0]  active_len_type;

   typedef struct packed {
      row_type row;
      len_type len;
      logic    found;
      idx_type pivot;
      idx_type swap_idx;
   } swap_plan_type;

   function automatic elem_type get_lane(row_type row, idx_type idx);
      return row[idx * ELEMENT_WIDTH +: ELEMENT_WIDTH];
   endfunction

endpackage

>>> hdl/nlp_req_if.sv
// Input channel carrying one packed row per transfer.
// Depends on nlp_pkg.
`timescale 1ns / 1ps

interface nlp_req_if import nlp_pkg::*; ();
   logic    valid;
   logic    ready;
   row_type row_in;

   modport source (output valid, output row_in, input ready);
   modport sink (input valid, input row_in, output ready);
endinterface

>>> hdl/nlp_rsp_if.sv
// Result channel carrying the next arrangement and its flag per transfer.
// Depends on nlp_pkg.
`timescale 1ns / 1ps

interface nlp_rsp_if import nlp_pkg::*; ();
   logic    valid;
   logic    ready;
   row_type row_out;
   logic    advanced;

   modport source (output valid, output row_out, output advanced, input ready);
   modport sink (input valid, input row_out, input advanced, output ready);
endinterface

>>> hdl/next_lexicographic_permutation.sv
// A request row passes through four register stages in order (ascent compare, pivot
// select, swap search, reorder) before its result is offered on the result channel.
// Throughput: one row per cycle while the result channel does not stall; a stalled
// result lets empty stages close up and then holds the whole pipe. Reset clears every
// stage valid bit and sets active_length to eight. Top level; depends on nlp_pkg,
// nlp_req_if, nlp_rsp_if, nlp_reorder.
`timescale 1ns / 1ps

module next_lexicographic_permutation import nlp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  active_len_type csr_write_data,
   nlp_req_if.sink        req_ch,
   nlp_rsp_if.source      rsp_ch
);

   active_len_type active_length_ff;

   logic                     s1_valid_ff;
   row_type                  s1_row_ff;
   len_type                  s1_len_ff;
   logic [ELEMENT_COUNT-2:0] s1_asc_ff;
   len_type                  s1_len_in;
   logic [ELEMENT_COUNT-2:0] s1_asc_in;

   logic     s2_valid_ff;
   row_type  s2_row_ff;
   len_type  s2_len_ff;
   logic     s2_found_ff;
   idx_type  s2_pivot_ff;
   elem_type s2_pivot_val_ff;
   logic     s2_found_in;
   idx_type  s2_pivot_in;
   elem_type s2_pivot_val_in;

   logic          s3_valid_ff;
   swap_plan_type s3_plan_ff;
   swap_plan_type s3_plan_in;

   logic    out_valid_ff;
   row_type out_row_ff;
   logic    out_advanced_ff;
   row_type out_row_in;

   logic s1_ready;
   logic s2_ready;
   logic s3_ready;
   logic out_ready;

   assign out_ready    = !out_valid_ff || rsp_ch.ready;
   assign s3_ready     = !s3_valid_ff || out_ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= ACTIVE_LEN_W'(ELEMENT_COUNT);
      end else if (csr_write_enable) begin
         active_length_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (active_length_ff > ACTIVE_LEN_W'(ELEMENT_COUNT)) begin
         s1_len_in = LEN_W'(ELEMENT_COUNT);
      end else begin
         s1_len_in = LEN_W'(active_length_ff);
      end
      for (int i = 0; i < ELEMENT_COUNT - 1; i++) begin
         s1_asc_in[i] = (LEN_W'(i + 1) < s1_len_in) &&
            (get_lane(req_ch.row_in, IDX_W'(i)) < get_lane(req_ch.row_in, IDX_W'(i + 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_row_ff <= req_ch.row_in;
         s1_len_ff <= s1_len_in;
         s1_asc_ff <= s1_asc_in;
      end
   end

   always_comb begin
      s2_found_in = |s1_asc_ff;
      s2_pivot_in = '0;
      for (int i = 0; i < ELEMENT_COUNT - 1; i++) begin
         if (s1_asc_ff[i]) begin
            s2_pivot_in = IDX_W'(i);
         end
      end
      s2_pivot_val_in = get_lane(s1_row_ff, s2_pivot_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_row_ff       <= s1_row_ff;
         s2_len_ff       <= s1_len_ff;
         s2_found_ff     <= s2_found_in;
         s2_pivot_ff     <= s2_pivot_in;
         s2_pivot_val_ff <= s2_pivot_val_in;
      end
   end

   always_comb begin
      s3_plan_in.row      = s2_row_ff;
      s3_plan_in.len      = s2_len_ff;
      s3_plan_in.found    = s2_found_ff;
      s3_plan_in.pivot    = s2_pivot_ff;
      s3_plan_in.swap_idx = '0;
      for (int j = 1; j < ELEMENT_COUNT; j++) begin
         if ((IDX_W'(j) > s2_pivot_ff) && (LEN_W'(j) < s2_len_ff) &&
             (get_lane(s2_row_ff, IDX_W'(j)) > s2_pivot_val_ff)) begin
            s3_plan_in.swap_idx = IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_plan_ff <= s3_plan_in;
      end
   end

   nlp_reorder u_reorder (
      .plan    (s3_plan_ff),
      .row_out (out_row_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_row_ff      <= out_row_in;
         out_advanced_ff <= s3_plan_ff.found;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.row_out  = out_row_ff;
   assign rsp_ch.advanced = out_advanced_ff;

endmodule

>>> hdl/nlp_reorder.sv
// Swap and suffix reversal network of the last pipeline stage.
// Depends on nlp_pkg.
`timescale 1ns / 1ps

module nlp_reorder import nlp_pkg::*; (
   input  swap_plan_type plan,
   output row_type       row_out
);

   logic [SRC_W-1:0] src [ELEMENT_COUNT];
   idx_type          src_idx [ELEMENT_COUNT];
   elem_type         lane [ELEMENT_COUNT];

   always_comb begin
      row_out = plan.row;
      for (int k = 0; k < ELEMENT_COUNT; k++) begin
         // Lane k of the reversed suffix takes the element mirrored about it.
         src[k]     = SRC_W'(plan.pivot) + SRC_W'(plan.len) - SRC_W'(k);
         src_idx[k] = src[k][IDX_W-1:0];
         if (IDX_W'(k) == plan.pivot) begin
            lane[k] = get_lane(plan.row, plan.swap_idx);
         end else if (IDX_W'(k) > plan.pivot) begin
            if (src_idx[k] == plan.swap_idx) begin
               lane[k] = get_lane(plan.row, plan.pivot);
            end else begin
               lane[k] = get_lane(plan.row, src_idx[k]);
            end
         end else begin
            lane[k] = get_lane(plan.row, IDX_W'(k));
         end
         if (plan.found && (LEN_W'(k) < plan.len)) begin
            row_out[k*ELEMENT_WIDTH +: ELEMENT_WIDTH] = lane[k];
         end
      end
   end

endmodule

>>> hdl/nlp_checker.sv
// Port-level checker for next_lexicographic_permutation, with its bind.
// Depends on next_lexicographic_permutation_macros.svh.
`timescale 1ns / 1ps
`include "next_lexicographic_permutation_macros.svh"

module nlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_row_out,
   input logic        rsp_advanced
);

   // A waiting result must hold still until its transfer.
   `NLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_out) && $stable(rsp_advanced), "result changed while stalled")

   // An empty or draining output stage lets the whole pipeline move.
   `NLP_ASSERT_SAME(a_req_ready, clock, reset, !rsp_valid || rsp_ready, req_ready, "request side stalled without a result stall")

   // After reset the pipeline is empty and open for a new row.
   `NLP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_row_out  (rsp_ch.row_out),
   .rsp_advanced (rsp_ch.advanced)
);
